@@ hw/rtl/lbh_pkg.sv @@
// Shared types and constants for the letter bigram histogram.
package lbh_pkg;

  // Table geometry: 27 letter indexes per side, one cell per pair.
  localparam int unsigned ALPHA     = 27;
  localparam int unsigned CELLS     = ALPHA * ALPHA;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned AMOUNT_W  = 32;
  localparam int unsigned RESULT_W  = 32;

  // Character ranges that map onto letter indexes 1..26.
  localparam logic [7:0] CHAR_UPPER_FIRST = 8'd65;
  localparam logic [7:0] CHAR_UPPER_LAST  = 8'd90;
  localparam logic [7:0] CHAR_LOWER_FIRST = 8'd97;
  localparam logic [7:0] CHAR_LOWER_LAST  = 8'd122;
  localparam logic [7:0] CHAR_UPPER_BIAS  = 8'd64;
  localparam logic [7:0] CHAR_LOWER_BIAS  = 8'd96;

  typedef enum logic [1:0] {
    OP_STREAM = 2'd0,
    OP_ADD    = 2'd1,
    OP_READ   = 2'd2
  } lbh_op_t;

  // One decoded operation on its way to the table.
  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic                out_of_range;
    logic [ADDR_W-1:0]   addr;
    logic [AMOUNT_W-1:0] amount;
  } lbh_item_t;

endpackage

@@ hw/rtl/letter_bigram_histogram_top.sv @@
// Top level of the letter bigram histogram: stream ports, pipeline and count table.
//
// This block keeps a 27 x 27 table of saturating pair counts, one cell per ordered pair of
// letter indexes, where A-Z and a-z map to 1..26 and every other byte maps to 0. An item with
// op 0 streams one character: unless it starts a string (or is the first character since
// reset) it adds one to the cell of the previous and current character. Op 1 adds amount to
// the cell of the pair letter_a, letter_b. Op 2 reads cell (read_row, read_col) and returns
// one result item carrying the count, or zero when either index is above 26; op 3 is ignored.
// Counts stop at 2^COUNT_WIDTH - 1, and a result carries the low 32 bits of the count. The
// block takes one item per clock cycle when input is not held off: an item is registered at
// the input, the table is read while it sits there, and the update stage writes the updated
// count back, with the fresh value forwarded when two items in a row hit the same cell. A
// read result passes from the input register through the update stage into an output
// register on the master side. Apart from the table sweep after reset, input is held off
// only while that register holds a result that is not taken and another read is waiting
// behind it. The sweep zeroes one cell per cycle, and no item is accepted until it ends.
module letter_bigram_histogram_top import lbh_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // letter_a [7:0], letter_b [15:8], amount [47:16], read_row [52:48], read_col [57:53]
  input  logic [63:0] s_tdata,
  // op [1:0], starts_string [2]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_count [31:0]
  output logic [31:0] m_tdata
);

  lbh_item_t              item;
  logic                   accept;
  logic                   advance;
  logic                   busy;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // The whole pipeline moves together; input is taken only when it advances and the clear sweep is done.
  assign s_tready = advance && !busy;
  assign accept   = s_tvalid && s_tready;

  lbh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .advance       (advance),
    .op            (s_tuser[1:0]),
    .letter_a      (s_tdata[7:0]),
    .letter_b      (s_tdata[15:8]),
    .starts_string (s_tuser[2]),
    .amount        (s_tdata[47:16]),
    .read_row      (s_tdata[52:48]),
    .read_col      (s_tdata[57:53]),
    .item          (item)
  );

  // The RAM read is enabled only when the pipeline advances, so a stalled read keeps its data.
  lbh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CELLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (item.addr),
    .rdata (ram_rdata)
  );

  lbh_update #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ram_rdata    (ram_rdata),
    .result_ready (m_tready),
    .advance      (advance),
    .busy         (busy),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .result_valid (m_tvalid),
    .result_count (m_tdata)
  );

endmodule

@@ hw/rtl/lbh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lbh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 729
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lbh_front.sv @@
// Input decode: letter mapping, previous-character tracking and the input register.
module lbh_front import lbh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                advance,
  input  logic [1:0]          op,
  input  logic [7:0]          letter_a,
  input  logic [7:0]          letter_b,
  input  logic                starts_string,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic [INDEX_W-1:0]  read_row,
  input  logic [INDEX_W-1:0]  read_col,
  output lbh_item_t           item
);

  logic [INDEX_W-1:0] prev_index;
  logic               prev_valid;
  lbh_item_t          item_next;
  logic [INDEX_W-1:0] index_a;
  logic [INDEX_W-1:0] index_b;
  logic [INDEX_W-1:0] row;
  logic [INDEX_W-1:0] col;

  function automatic logic [INDEX_W-1:0] letter_index(input logic [7:0] c);
    logic [7:0] diff;
    diff = '0;
    if (c >= CHAR_UPPER_FIRST && c <= CHAR_UPPER_LAST) begin
      diff = c - CHAR_UPPER_BIAS;
    end else if (c >= CHAR_LOWER_FIRST && c <= CHAR_LOWER_LAST) begin
      diff = c - CHAR_LOWER_BIAS;
    end
    return diff[INDEX_W-1:0];
  endfunction

  assign index_a = letter_index(letter_a);
  assign index_b = letter_index(letter_b);

  always_comb begin
    item_next              = '0;
    row                    = '0;
    col                    = '0;
    item_next.amount       = amount;
    case (lbh_op_t'(op))
      OP_STREAM: begin
        // A pair is counted only when a previous character belongs to this string.
        row                = prev_index;
        col                = index_a;
        item_next.valid    = accept && !starts_string && prev_valid;
        item_next.amount   = AMOUNT_W'(1);
      end
      OP_ADD: begin
        row                = index_a;
        col                = index_b;
        item_next.valid    = accept;
      end
      OP_READ: begin
        item_next.valid    = accept;
        item_next.is_read  = 1'b1;
        item_next.out_of_range = (read_row >= INDEX_W'(ALPHA)) ||
                                 (read_col >= INDEX_W'(ALPHA));
        if (!item_next.out_of_range) begin
          row              = read_row;
          col              = read_col;
        end
      end
      default: begin
        item_next.valid    = 1'b0;
      end
    endcase
    item_next.addr = ADDR_W'(row) * ADDR_W'(ALPHA) + ADDR_W'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      prev_index <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (advance) begin
        item <= item_next;
      end
      if (accept && lbh_op_t'(op) == OP_STREAM) begin
        prev_index <= index_a;
        prev_valid <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/lbh_update.sv @@
// Table update stage: saturating add, write-back forwarding, clear sweep and result register.
module lbh_update import lbh_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lbh_item_t              item,
  input  logic [COUNT_WIDTH-1:0] ram_rdata,
  input  logic                   result_ready,
  output logic                   advance,
  output logic                   busy,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [COUNT_WIDTH-1:0] ram_wdata,
  output logic                   result_valid,
  output logic [RESULT_W-1:0]    result_count
);

  localparam int unsigned SUM_W =
    ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;

  lbh_item_t              stage;
  logic                   fwd_hit;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic                   clearing;
  logic [ADDR_W-1:0]      clr_addr;
  logic [COUNT_WIDTH-1:0] current;
  logic [SUM_W-1:0]       current_ext;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_WIDTH-1:0] saturated;
  logic                   stage_writes;
  logic                   result_free;

  // A cell written on the previous edge is not yet in the RAM read data.
  assign current     = fwd_hit ? fwd_data : ram_rdata;
  assign current_ext = SUM_W'(current);
  assign sum         = current_ext + SUM_W'(stage.amount);
  assign saturated   = (|sum[SUM_W-1:COUNT_WIDTH]) ? {COUNT_WIDTH{1'b1}}
                                                   : sum[COUNT_WIDTH-1:0];

  assign result_free  = !result_valid || result_ready;
  assign advance      = !stage.valid || !stage.is_read || result_free;
  assign stage_writes = stage.valid && !stage.is_read;
  assign busy         = clearing;

  assign ram_we    = clearing || (advance && stage_writes);
  assign ram_waddr = clearing ? clr_addr : stage.addr;
  assign ram_wdata = clearing ? '0 : saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid  <= 1'b0;
      fwd_hit      <= 1'b0;
      result_valid <= 1'b0;
      clearing     <= 1'b1;
      clr_addr     <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        stage    <= item;
        fwd_hit  <= item.valid && stage_writes && (item.addr == stage.addr);
        fwd_data <= saturated;
      end
      if (advance && stage.valid && stage.is_read) begin
        result_valid <= 1'b1;
        result_count <= stage.out_of_range ? '0 : current_ext[RESULT_W-1:0];
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/lbh_checker.sv @@
// Port-level assertions for the letter bigram histogram, bound to the top level.
module lbh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // The table sweep after reset keeps the input closed.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // No result can exist in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

endmodule

bind letter_bigram_histogram_top lbh_checker u_lbh_checker (.*);

@@ bench/tb_letter_bigram_histogram_top.sv @@
// Self-checking testbench for the letter bigram histogram top level.
`timescale 1ns / 1ps

module tb_letter_bigram_histogram_top import lbh_pkg::*; ();

  // The table is built with its default count width.
  localparam int COUNT_W = 32;
  // Least number of counted items in the random part.
  localparam int RANDOM_ITEMS = 1500;
  // The limit is well above the slowest correct run, which includes the
  // table sweep after reset and the long hold-off on the result side.
  localparam int CYCLE_LIMIT = 300000;
  // Length of the one long stall on the result side.
  localparam int HOLD_CYCLES = 400;
  // Operation code that the block drops without a result.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // One input item, field by field, as the block sees it.
  typedef struct {
    logic [1:0]         op;
    logic [7:0]         letter_a;
    logic [7:0]         letter_b;
    logic               starts_string;
    logic [31:0]        amount;
    logic [INDEX_W-1:0] read_row;
    logic [INDEX_W-1:0] read_col;
  } bigram_item_t;

  // The tally mirrors the pair table and keeps the counts that read items
  // must return, oldest first.
  class bigram_tally;
    bit [COUNT_W-1:0]   counts [CELLS];
    bit [INDEX_W-1:0]   prev_index;
    bit                 prev_valid;
    logic [RESULT_W-1:0] expected_counts [$];
    int                 failures;
    int                 last_row;
    int                 last_col;

    function new();
      foreach (counts[i]) counts[i] = '0;
      prev_index = '0;
      prev_valid = 1'b0;
      failures   = 0;
      last_row   = 0;
      last_col   = 0;
    endfunction

    // Letters of either case map to 1..26; any other byte maps to 0.
    function bit [INDEX_W-1:0] letter_slot(bit [7:0] ch);
      if (ch >= CHAR_UPPER_FIRST && ch <= CHAR_UPPER_LAST) return INDEX_W'(ch - CHAR_UPPER_BIAS);
      if (ch >= CHAR_LOWER_FIRST && ch <= CHAR_LOWER_LAST) return INDEX_W'(ch - CHAR_LOWER_BIAS);
      return '0;
    endfunction

    function void add_saturating(int row, int col, bit [63:0] amt);
      bit [64:0] sum;
      bit [64:0] ceiling;
      ceiling = (65'd1 << COUNT_W) - 65'd1;
      sum = 65'(counts[row * ALPHA + col]) + 65'(amt);
      counts[row * ALPHA + col] = (sum > ceiling) ? COUNT_W'(ceiling) : COUNT_W'(sum);
      last_row = row;
      last_col = col;
    endfunction

    function void note_item(bigram_item_t it);
      bit [INDEX_W-1:0] cur;
      case (it.op)
        OP_STREAM: begin
          cur = letter_slot(it.letter_a);
          // No pair before the first character or at the start of a string.
          if (!it.starts_string && prev_valid)
            add_saturating(int'(prev_index), int'(cur), 64'd1);
          prev_index = cur;
          prev_valid = 1'b1;
        end
        OP_ADD: begin
          add_saturating(int'(letter_slot(it.letter_a)), int'(letter_slot(it.letter_b)),
                         64'(it.amount));
        end
        OP_READ: begin
          if (it.read_row < ALPHA && it.read_col < ALPHA)
            expected_counts.push_back(counts[it.read_row * ALPHA + it.read_col][RESULT_W-1:0]);
          else
            expected_counts.push_back('0);
        end
        default: ;
      endcase
    endfunction

    function void check_count(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: result item with no read waiting, cell_count %h", $time, got);
        failures++;
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        $display("%0t: cell_count mismatch, expected %h actual %h", $time, want, got);
        failures++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  bigram_tally tally;
  int items_sent = 0;
  int send_calm  = 0;
  // The stimulus asks once for the long stall; the result side carries it out.
  bit hold_asked = 1'b0;
  bit hold_done  = 1'b0;

  letter_bigram_histogram_top #(
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Wait before the next item: mostly a random gap, with calm stretches of
  // back-to-back items now and then.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Mostly letters of both cases, sometimes any byte at all.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'(CHAR_UPPER_FIRST + $urandom_range(0, 25));
    if (r < 8) return 8'(CHAR_LOWER_FIRST + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Fields that an operation does not use still carry random bits.
  function automatic bigram_item_t noise_item();
    bigram_item_t it;
    it.op            = 2'($urandom_range(0, 3));
    it.letter_a      = 8'($urandom);
    it.letter_b      = 8'($urandom);
    it.starts_string = 1'($urandom);
    it.amount        = $urandom;
    it.read_row      = INDEX_W'($urandom);
    it.read_col      = INDEX_W'($urandom);
    return it;
  endfunction

  function automatic bigram_item_t make_stream(logic [7:0] ch, logic starts);
    bigram_item_t it;
    it = noise_item();
    it.op            = OP_STREAM;
    it.letter_a      = ch;
    it.starts_string = starts;
    return it;
  endfunction

  function automatic bigram_item_t make_add(logic [7:0] a, logic [7:0] b, logic [31:0] amt);
    bigram_item_t it;
    it = noise_item();
    it.op       = OP_ADD;
    it.letter_a = a;
    it.letter_b = b;
    it.amount   = amt;
    return it;
  endfunction

  function automatic bigram_item_t make_read(int row, int col);
    bigram_item_t it;
    it = noise_item();
    it.op       = OP_READ;
    it.read_row = INDEX_W'(row);
    it.read_col = INDEX_W'(col);
    return it;
  endfunction

  // Offers one item after a random gap and notes it once it is accepted.
  // Entered and left at a falling edge, so valid stays high between items
  // that follow without a gap.
  task automatic send_item(input bigram_item_t it);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    // Slave data: letter_a, letter_b, amount, read_row, read_col from bit 0 up.
    s_tdata  <= {6'd0, it.read_col, it.read_row, it.amount, it.letter_b, it.letter_a};
    // Slave user: op, then starts_string.
    s_tuser  <= {it.starts_string, it.op};
    do @(posedge clk); while (!s_tready);
    tally.note_item(it);
    if (it.op != OP_IGNORED) items_sent++;
    @(negedge clk);
  endtask

  // Result side: stalls at random before each result, once for a long
  // stretch so that pending reads back up and the input side stalls.
  initial begin : result_sink
    int stall;
    int calm;
    calm = 0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_asked && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = draw_wait(calm);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tally.check_count(m_tdata);
      @(negedge clk);
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** letter_bigram_histogram_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    bigram_item_t it;
    int           pick;
    int           word_len;
    logic [7:0]   ch;
    logic [7:0]   prev_ch;
    logic [31:0]  amt;

    tally = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The very first character after reset forms no pair even
    // though starts_string is low.
    send_item(make_stream(CHAR_UPPER_FIRST, 1'b0));
    send_item(make_stream(8'(CHAR_UPPER_FIRST + 1), 1'b0));
    // Edges of both letter ranges and the bytes just outside them.
    send_item(make_stream(CHAR_LOWER_LAST, 1'b0));
    send_item(make_stream(CHAR_UPPER_BIAS, 1'b0));
    send_item(make_stream(8'(CHAR_UPPER_LAST + 1), 1'b0));
    send_item(make_stream(CHAR_LOWER_BIAS, 1'b0));
    send_item(make_stream(8'(CHAR_LOWER_LAST + 1), 1'b0));
    // A new string forms no pair with what came before.
    send_item(make_stream(CHAR_LOWER_FIRST, 1'b1));
    send_item(make_stream(CHAR_UPPER_LAST, 1'b0));
    send_item(make_stream(8'hFF, 1'b0));
    // Saturation: the largest amount, then one more by add and by a pair.
    send_item(make_add(CHAR_UPPER_LAST, CHAR_LOWER_LAST, 32'hFFFF_FFFF));
    send_item(make_add(CHAR_UPPER_LAST, CHAR_LOWER_LAST, 32'd1));
    send_item(make_add(8'h00, 8'hFF, 32'd0));
    send_item(make_stream(CHAR_LOWER_LAST, 1'b1));
    send_item(make_stream(CHAR_UPPER_LAST, 1'b0));
    send_item(make_read(26, 26));
    send_item(make_read(1, 2));
    send_item(make_read(0, 0));
    send_item(make_read(26, 0));
    // Reads outside the table return zero.
    send_item(make_read(27, 0));
    send_item(make_read(0, 31));
    send_item(make_read(31, 31));
    // The unused operation code, with every data bit set.
    it = make_read(31, 31);
    it.op = OP_IGNORED;
    it.letter_a = 8'hFF;
    it.letter_b = 8'hFF;
    it.amount = 32'hFFFF_FFFF;
    it.starts_string = 1'b1;
    send_item(it);
    send_item(make_read(2, 26));
    send_item(make_read(1, 26));

    // Random part: words of text dominate, mixed with adds, reads and noise.
    while (items_sent < RANDOM_ITEMS + 25) begin
      if (items_sent > 300) hold_asked = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // Runs of a repeated letter hit the same cell on successive items.
        word_len = $urandom_range(1, 8);
        prev_ch = 8'h00;
        for (int k = 0; k < word_len; k++) begin
          ch = (k > 0 && $urandom_range(0, 3) == 0) ? prev_ch : pick_char();
          send_item(make_stream(ch, (k == 0) ? ($urandom_range(0, 7) != 0)
                                             : ($urandom_range(0, 19) == 0)));
          prev_ch = ch;
        end
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0:       amt = $urandom;
          1:       amt = $urandom_range(0, 255);
          default: amt = 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
        send_item(make_add(pick_char(), pick_char(), amt));
      end else if (pick < 95) begin
        // Reading the cell touched last also exercises the write forwarding.
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: send_item(make_read(tally.last_row, tally.last_col));
          8, 9, 10:               send_item(make_read($urandom_range(0, 31),
                                                      $urandom_range(0, 31)));
          default:                send_item(make_read($urandom_range(0, 26),
                                                      $urandom_range(0, 26)));
        endcase
      end else begin
        send_item(noise_item());
      end
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding reads, then allow a few cycles for stray results.
    while (tally.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tally.failures == 0)
      $display("** letter_bigram_histogram_top: PASSED **");
    else
      $display("** letter_bigram_histogram_top: FAILED **");
    $finish;
  end

endmodule
